// File: rtl/core/cscc_pkg.sv
// shared constants and types for the cycling speed and cadence calculator
package cscc_pkg;

  localparam int unsigned DEF_COUNT_BITS = 16;
  localparam int unsigned CIRC_W         = 12;
  localparam int unsigned CADENCE_W      = 8;
  localparam int unsigned SPEED_W        = 16;
  localparam int unsigned TIMEOUT_W      = 3;

  localparam int unsigned CADENCE_K      = 60000;
  localparam int unsigned MM_PER_M       = 1000;
  localparam int unsigned CADENCE_MAX    = 200;
  localparam int unsigned SPEED_MAX      = 35000;
  localparam int unsigned TIMEOUT_LIMIT  = 3;

  // scale factor width: covers 60000 and circumference * 1000
  localparam int unsigned K_W            = 22;
  // quotient bits: every in-range rate is below 2^Q_BITS
  localparam int unsigned Q_BITS         = 16;

  typedef struct packed {
    logic valid;
    logic sel_wheel;
  } rate_req_t;

  typedef struct packed {
    logic              done;
    logic [Q_BITS-1:0] value;
  } rate_rsp_t;

endpackage

// File: rtl/core/cscc_rate_unit.sv
// iterative rate unit: one shared multiplier and one shared subtract/compare
module cscc_rate_unit #(
  parameter int unsigned COUNT_BITS = cscc_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cscc_pkg::rate_req_t                 req_i,
  input  logic [COUNT_BITS-1:0]               d_rev_i,
  input  logic [COUNT_BITS-1:0]               d_time_i,
  input  logic [cscc_pkg::CIRC_W-1:0]         circ_i,
  output cscc_pkg::rate_rsp_t                 rsp_o
);
  import cscc_pkg::*;

  localparam int unsigned B_W   = (COUNT_BITS > Q_BITS) ? COUNT_BITS : Q_BITS;
  localparam int unsigned NUM_W = K_W + B_W;
  localparam int unsigned CNT_W = $clog2(Q_BITS);

  typedef enum logic [5:0] {
    R_IDLE  = 6'b000001,
    R_MUL_K = 6'b000010,
    R_MUL_N = 6'b000100,
    R_MUL_L = 6'b001000,
    R_CMP   = 6'b010000,
    R_DIV   = 6'b100000
  } rate_state_e;

  rate_state_e       state_q, state_d;
  logic              sel_q;
  logic              done_q;
  logic [NUM_W-1:0]  mul_q;
  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  ds_q;
  logic [Q_BITS-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [K_W-1:0]    mul_a;
  logic [B_W-1:0]    mul_b;
  logic [NUM_W-1:0]  prod;
  logic [NUM_W-1:0]  cmp_rhs;
  logic [NUM_W:0]    diff;
  logic              ge;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      R_MUL_K: begin
        mul_a = sel_q ? K_W'(MM_PER_M) : K_W'(CADENCE_K);
        mul_b = sel_q ? B_W'(circ_i) : B_W'(1);
      end
      R_MUL_N: begin
        mul_a = mul_q[K_W-1:0];
        mul_b = B_W'(d_rev_i);
      end
      R_MUL_L: begin
        mul_a = sel_q ? K_W'(SPEED_MAX + 1) : K_W'(CADENCE_MAX + 1);
        mul_b = B_W'(d_time_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = NUM_W'(mul_a) * NUM_W'(mul_b);
  assign cmp_rhs = (state_q == R_CMP) ? mul_q : ds_q;
  assign diff    = {1'b0, rem_q} - {1'b0, cmp_rhs};
  assign ge      = ~diff[NUM_W];

  always_comb begin
    state_d = state_q;
    case (state_q)
      R_IDLE:  if (req_i.valid) state_d = R_MUL_K;
      R_MUL_K: state_d = R_MUL_N;
      R_MUL_N: state_d = R_MUL_L;
      R_MUL_L: state_d = R_CMP;
      R_CMP:   state_d = ge ? R_IDLE : R_DIV;
      R_DIV:   if (cnt_q == '0) state_d = R_IDLE;
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == R_CMP) && ge) || ((state_q == R_DIV) && (cnt_q == '0));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      R_IDLE: begin
        if (req_i.valid) sel_q <= req_i.sel_wheel;
      end
      R_MUL_K: mul_q <= prod;
      R_MUL_N: mul_q <= prod;
      R_MUL_L: begin
        rem_q <= mul_q;
        mul_q <= prod;
      end
      R_CMP: begin
        // over the limit, or zero time delta
        quo_q <= '0;
        ds_q  <= NUM_W'(d_time_i) << (Q_BITS - 1);
        cnt_q <= CNT_W'(Q_BITS - 1);
      end
      R_DIV: begin
        if (ge) rem_q <= diff[NUM_W-1:0];
        quo_q <= {quo_q[Q_BITS-2:0], ge};
        ds_q  <= ds_q >> 1;
        cnt_q <= cnt_q - CNT_W'(1);
      end
      default: begin
        mul_q <= mul_q;
      end
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = quo_q;

endmodule

// File: rtl/core/cycling_speed_cadence_calc_unit.sv
// top level of the cycling speed and cadence calculator
//
// input channel (in_valid_i / in_ready_o) carries either a sensor packet (mode_i = 0)
// with cumulative crank and wheel counts and event times, or a watchdog tick (mode_i = 1).
// every accepted item produces exactly one transfer on the output channel
// (out_valid_o / out_ready_i) with the held cadence, speed and the two armed flags.
// the config channel (cfg_valid_i / cfg_data_i / cfg_ready_o) writes the wheel size in mm;
// it is always ready and should only be used while the block is idle.
// after an item is accepted, a tick goes straight to the finish state; a packet first
// sends each channel that needs a new rate, crank first, through the rate unit, which
// skips the divide when the rate is over its limit or the time delta is zero;
// in_ready_o rises with out_valid_o.
// the rate unit runs 3 multiplies, 1 limit compare and 16 restoring divide steps per
// channel, one step per cycle; the block takes no new item until that is done.
// an unread result sits in the output register while the next item is worked on; if it
// is still unread when the next result is ready, the block waits. reset clears all stored
// counts, times, rates, watchdogs, armed flags and the wheel size, but not the output data.
module cycling_speed_cadence_calc_unit #(
  parameter int unsigned COUNT_BITS = cscc_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [COUNT_BITS-1:0]             crank_revs_i,
  input  logic [COUNT_BITS-1:0]             crank_time_i,
  input  logic [COUNT_BITS-1:0]             wheel_revs_i,
  input  logic [COUNT_BITS-1:0]             wheel_time_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cscc_pkg::CADENCE_W-1:0]    cadence_rpm_o,
  output logic [cscc_pkg::SPEED_W-1:0]      speed_mm_per_s_o,
  output logic                              cadence_armed_o,
  output logic                              speed_armed_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cscc_pkg::CIRC_W-1:0]       cfg_data_i
);
  import cscc_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_NEXT = 4'b0010,
    T_WAIT = 4'b0100,
    T_FIN  = 4'b1000
  } top_state_e;

  top_state_e state_q;

  logic [CIRC_W-1:0]       circ_q;
  logic [COUNT_BITS-1:0]   last_crank_q, last_crank_time_q;
  logic [COUNT_BITS-1:0]   last_wheel_q, last_wheel_time_q;
  logic [COUNT_BITS-1:0]   drev_c_q, dt_c_q, drev_w_q, dt_w_q;
  logic [TIMEOUT_W-1:0]    cad_to_q, spd_to_q;
  logic [CADENCE_W-1:0]    cadence_value_q;
  logic [SPEED_W-1:0]      speed_value_q;
  logic                    cad_seen_q, spd_seen_q;
  logic                    need_c_q, need_w_q;
  logic                    ch_q;
  logic                    out_valid_q;
  logic [CADENCE_W-1:0]    out_cad_q;
  logic [SPEED_W-1:0]      out_spd_q;
  logic                    out_cad_arm_q, out_spd_arm_q;

  logic                    in_xfer, out_free, c_chg, w_chg;
  rate_req_t               rate_req;
  rate_rsp_t               rate_rsp;

  assign in_ready_o  = (state_q == T_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign c_chg       = (crank_revs_i != last_crank_q);
  assign w_chg       = (wheel_revs_i != last_wheel_q) && (circ_q != '0);

  assign rate_req.valid     = (state_q == T_NEXT) && (need_c_q || need_w_q);
  assign rate_req.sel_wheel = !need_c_q;

  cscc_rate_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_rate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (rate_req),
    .d_rev_i  (ch_q ? drev_w_q : drev_c_q),
    .d_time_i (ch_q ? dt_w_q : dt_c_q),
    .circ_i   (circ_q),
    .rsp_o    (rate_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= T_IDLE;
      circ_q            <= '0;
      last_crank_q      <= '0;
      last_crank_time_q <= '0;
      last_wheel_q      <= '0;
      last_wheel_time_q <= '0;
      cad_to_q          <= '0;
      spd_to_q          <= '0;
      cadence_value_q   <= '0;
      speed_value_q     <= '0;
      cad_seen_q        <= 1'b0;
      spd_seen_q        <= 1'b0;
      need_c_q          <= 1'b0;
      need_w_q          <= 1'b0;
      ch_q              <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) circ_q <= cfg_data_i;
      if (out_valid_q && out_ready_i && (state_q != T_FIN)) out_valid_q <= 1'b0;

      case (state_q)
        T_IDLE: begin
          if (in_xfer) begin
            if (mode_i) begin
              // watchdog tick
              if (cad_to_q > TIMEOUT_W'(TIMEOUT_LIMIT)) begin
                cad_to_q        <= '0;
                cadence_value_q <= '0;
              end else begin
                cad_to_q <= cad_to_q + TIMEOUT_W'(1);
              end
              if (spd_to_q > TIMEOUT_W'(TIMEOUT_LIMIT)) begin
                spd_to_q      <= '0;
                speed_value_q <= '0;
              end else begin
                spd_to_q <= spd_to_q + TIMEOUT_W'(1);
              end
              need_c_q <= 1'b0;
              need_w_q <= 1'b0;
              state_q  <= T_FIN;
            end else begin
              need_c_q <= c_chg && cad_seen_q;
              need_w_q <= w_chg && spd_seen_q;
              if (c_chg) begin
                cad_seen_q        <= 1'b1;
                last_crank_q      <= crank_revs_i;
                last_crank_time_q <= crank_time_i;
                cad_to_q          <= '0;
              end
              if (w_chg) begin
                spd_seen_q        <= 1'b1;
                last_wheel_q      <= wheel_revs_i;
                last_wheel_time_q <= wheel_time_i;
                spd_to_q          <= '0;
              end
              state_q <= T_NEXT;
            end
          end
        end
        T_NEXT: begin
          if (need_c_q) begin
            ch_q     <= 1'b0;
            need_c_q <= 1'b0;
            state_q  <= T_WAIT;
          end else if (need_w_q) begin
            ch_q     <= 1'b1;
            need_w_q <= 1'b0;
            state_q  <= T_WAIT;
          end else begin
            state_q <= T_FIN;
          end
        end
        T_WAIT: begin
          if (rate_rsp.done) begin
            if (ch_q) begin
              speed_value_q <= rate_rsp.value[SPEED_W-1:0];
            end else begin
              cadence_value_q <= rate_rsp.value[CADENCE_W-1:0];
            end
            state_q <= T_NEXT;
          end
        end
        T_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  // deltas modulo 2^COUNT_BITS, taken against the stored values before update
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      drev_c_q <= crank_revs_i - last_crank_q;
      dt_c_q   <= crank_time_i - last_crank_time_q;
      drev_w_q <= wheel_revs_i - last_wheel_q;
      dt_w_q   <= wheel_time_i - last_wheel_time_q;
    end
    if ((state_q == T_FIN) && out_free) begin
      out_cad_q     <= cadence_value_q;
      out_spd_q     <= speed_value_q;
      out_cad_arm_q <= cad_seen_q;
      out_spd_arm_q <= spd_seen_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cadence_rpm_o    = out_cad_q;
  assign speed_mm_per_s_o = out_spd_q;
  assign cadence_armed_o  = out_cad_arm_q;
  assign speed_armed_o    = out_spd_arm_q;

  a_cad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cadence_value_q <= CADENCE_W'(CADENCE_MAX))
    else $error("cadence above limit");

  a_spd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_value_q <= SPEED_W'(SPEED_MAX))
    else $error("speed above limit");

  a_to_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cad_to_q <= TIMEOUT_W'(TIMEOUT_LIMIT + 1)) && (spd_to_q <= TIMEOUT_W'(TIMEOUT_LIMIT + 1)))
    else $error("watchdog count out of range");

  a_rsp_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_rsp.done |-> (state_q == T_WAIT))
    else $error("rate result outside wait state");

  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_req.valid |=> !rate_rsp.done)
    else $error("rate result right after request");

endmodule

// File: bench/testbench.sv
// self-checking testbench for the cycling speed and cadence calculator
module testbench;
  import cscc_pkg::*;

  localparam int unsigned CNT_W         = DEF_COUNT_BITS;
  localparam logic        MODE_PACKET   = 1'b0;
  localparam logic        MODE_TICK     = 1'b1;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic             mode;
    logic [CNT_W-1:0] crank_revs;
    logic [CNT_W-1:0] crank_time;
    logic [CNT_W-1:0] wheel_revs;
    logic [CNT_W-1:0] wheel_time;
  } sensor_item_t;

  typedef struct packed {
    logic [CADENCE_W-1:0] cadence_rpm;
    logic [SPEED_W-1:0]   speed_mm_per_s;
    logic                 cadence_armed;
    logic                 speed_armed;
  } ride_reading_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    mode_i;
  logic [CNT_W-1:0]        crank_revs_i;
  logic [CNT_W-1:0]        crank_time_i;
  logic [CNT_W-1:0]        wheel_revs_i;
  logic [CNT_W-1:0]        wheel_time_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [CADENCE_W-1:0]    cadence_rpm_o;
  logic [SPEED_W-1:0]      speed_mm_per_s_o;
  logic                    cadence_armed_o;
  logic                    speed_armed_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CIRC_W-1:0]       cfg_data_i;

  cycling_speed_cadence_calc_unit #(
    .COUNT_BITS(CNT_W)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .crank_revs_i     (crank_revs_i),
    .crank_time_i     (crank_time_i),
    .wheel_revs_i     (wheel_revs_i),
    .wheel_time_i     (wheel_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cadence_rpm_o    (cadence_rpm_o),
    .speed_mm_per_s_o (speed_mm_per_s_o),
    .cadence_armed_o  (cadence_armed_o),
    .speed_armed_o    (speed_armed_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // predicted state of the block
  logic [CIRC_W-1:0]       circ_mm         = '0;
  logic [CNT_W-1:0]        crank_count_q   = '0;
  logic [CNT_W-1:0]        crank_stamp_q   = '0;
  logic [CNT_W-1:0]        wheel_count_q   = '0;
  logic [CNT_W-1:0]        wheel_stamp_q   = '0;
  logic [TIMEOUT_W-1:0]    cadence_wd      = '0;
  logic [TIMEOUT_W-1:0]    speed_wd        = '0;
  logic [CADENCE_W-1:0]    cadence_q       = '0;
  logic [SPEED_W-1:0]      speed_q         = '0;
  logic                    cadence_armed_q = 1'b0;
  logic                    speed_armed_q   = 1'b0;

  // simulated rider
  logic [CNT_W-1:0] ride_crank;
  logic [CNT_W-1:0] ride_ctime;
  logic [CNT_W-1:0] ride_wheel;
  logic [CNT_W-1:0] ride_wtime;

  ride_reading_t expected_readings[$];
  int unsigned   error_count = 0;
  int unsigned   gap_pct     = 0;
  int unsigned   stall_pct   = 0;
  int unsigned   hold_left   = 0;
  int unsigned   idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [CADENCE_W-1:0] cadence_from(logic [CNT_W-1:0] d_rev,
                                                        logic [CNT_W-1:0] d_time);
    longint unsigned r;
    if (d_time == 0) return '0;
    r = (64'(CADENCE_K) * d_rev) / d_time;
    return (r > CADENCE_MAX) ? '0 : r[CADENCE_W-1:0];
  endfunction

  function automatic logic [SPEED_W-1:0] speed_from(logic [CNT_W-1:0] d_rev,
                                                    logic [CNT_W-1:0] d_time);
    longint unsigned r;
    if (d_time == 0) return '0;
    r = (64'(circ_mm) * MM_PER_M * d_rev) / d_time;
    return (r > SPEED_MAX) ? '0 : r[SPEED_W-1:0];
  endfunction

  function automatic ride_reading_t predict_reading(sensor_item_t it);
    ride_reading_t rd;
    if (it.mode == MODE_PACKET) begin
      if (it.crank_revs != crank_count_q) begin
        if (cadence_armed_q)
          cadence_q = cadence_from(it.crank_revs - crank_count_q, it.crank_time - crank_stamp_q);
        else
          cadence_armed_q = 1'b1;
        crank_count_q = it.crank_revs;
        crank_stamp_q = it.crank_time;
        cadence_wd    = '0;
      end
      if (it.wheel_revs != wheel_count_q && circ_mm != 0) begin
        if (speed_armed_q)
          speed_q = speed_from(it.wheel_revs - wheel_count_q, it.wheel_time - wheel_stamp_q);
        else
          speed_armed_q = 1'b1;
        wheel_count_q = it.wheel_revs;
        wheel_stamp_q = it.wheel_time;
        speed_wd      = '0;
      end
    end else begin
      if (cadence_wd > TIMEOUT_LIMIT) begin
        cadence_wd = '0;
        cadence_q  = '0;
      end else begin
        cadence_wd = cadence_wd + 1'b1;
      end
      if (speed_wd > TIMEOUT_LIMIT) begin
        speed_wd = '0;
        speed_q  = '0;
      end else begin
        speed_wd = speed_wd + 1'b1;
      end
    end
    rd.cadence_rpm    = cadence_q;
    rd.speed_mm_per_s = speed_q;
    rd.cadence_armed  = cadence_armed_q;
    rd.speed_armed    = speed_armed_q;
    return rd;
  endfunction

  task automatic send_item(input sensor_item_t it);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    mode_i       <= it.mode;
    crank_revs_i <= it.crank_revs;
    crank_time_i <= it.crank_time;
    wheel_revs_i <= it.wheel_revs;
    wheel_time_i <= it.wheel_time;
    do @(posedge clk_i); while (!in_ready_o);
    expected_readings.push_back(predict_reading(it));
    gap = 0;
    while ($urandom_range(99) < gap_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_packet(input logic [CNT_W-1:0] c_rev, input logic [CNT_W-1:0] c_tim,
                             input logic [CNT_W-1:0] w_rev, input logic [CNT_W-1:0] w_tim);
    send_item('{MODE_PACKET, c_rev, c_tim, w_rev, w_tim});
  endtask

  task automatic send_tick();
    send_item('{MODE_TICK, CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                CNT_W'($urandom)});
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_circ(input logic [CIRC_W-1:0] size_mm);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size_mm;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    circ_mm      = size_mm;
    @(posedge clk_i);
  endtask

  // mostly plausible riding, some ticks, some random packets
  task automatic next_ride_item(output sensor_item_t it);
    int unsigned     pick;
    int unsigned     d_rev;
    int unsigned     target;
    longint unsigned dt;
    pick          = $urandom_range(99);
    it.mode       = MODE_PACKET;
    it.crank_revs = CNT_W'($urandom);
    it.crank_time = CNT_W'($urandom);
    it.wheel_revs = CNT_W'($urandom);
    it.wheel_time = CNT_W'($urandom);
    if (pick < 25) begin
      if (pick >= 10) it.mode = MODE_TICK;
    end else begin
      if ($urandom_range(3) != 0) begin
        d_rev      = $urandom_range(1, 3);
        ride_crank = ride_crank + CNT_W'(d_rev);
        ride_ctime = ride_ctime + CNT_W'(d_rev * $urandom_range(280, 2000));
      end else if ($urandom_range(1) != 0) begin
        ride_ctime = ride_ctime + CNT_W'($urandom_range(0, 5000));
      end
      if ($urandom_range(3) != 0) begin
        d_rev      = $urandom_range(1, 4);
        target     = $urandom_range(200, 40000);
        dt         = (64'(circ_mm) * MM_PER_M * d_rev) / target;
        if ($urandom_range(19) == 0) dt = 0;
        ride_wheel = ride_wheel + CNT_W'(d_rev);
        ride_wtime = ride_wtime + dt[CNT_W-1:0];
      end
      it.crank_revs = ride_crank;
      it.crank_time = ride_ctime;
      it.wheel_revs = ride_wheel;
      it.wheel_time = ride_wtime;
    end
  endtask

  task automatic ride_phase(input int unsigned n_items, input logic [CIRC_W-1:0] size_mm,
                            input int unsigned sender_idle, input int unsigned receiver_stall);
    sensor_item_t it;
    write_circ(size_mm);
    gap_pct    = sender_idle;
    stall_pct  = receiver_stall;
    ride_crank = CNT_W'($urandom);
    ride_ctime = CNT_W'($urandom);
    ride_wheel = CNT_W'($urandom);
    ride_wtime = CNT_W'($urandom);
    repeat (n_items) begin
      next_ride_item(it);
      send_item(it);
    end
    stop_sending();
  endtask

  task automatic test_directed_cases();
    gap_pct   = 0;
    stall_pct = 0;
    send_packet(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // crank arms, wheel ignored with zero wheel size
    send_packet(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_circ(12'hFFF);
    // count wrap, cadence too high; wheel arms
    send_packet(16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF);
    // zero time delta on crank, speed too high after wrap
    send_packet(16'h0002, 16'h0000, 16'h0000, 16'h0000);
    send_packet(16'h0003, 16'd300, 16'h0001, 16'd60000);
    send_packet(16'h0004, 16'd598, 16'h0001, 16'd0);
    send_packet(16'h0005, 16'd998, 16'h0001, 16'd0);
    send_packet(16'h0005, 16'd998, 16'h0001, 16'd60000);
    repeat (6) send_tick();
    send_packet(16'h0006, 16'd1598, 16'h0001, 16'd0);
    repeat (3) send_tick();
    // a change restarts the cadence watchdog
    send_packet(16'h0007, 16'd2198, 16'h0001, 16'd0);
    repeat (4) send_tick();
    write_circ(12'd3500);
    send_packet(16'h0007, 16'd0, 16'h0002, 16'd60100);
    send_tick();
    write_circ(12'd0);
    send_packet(16'h0007, 16'd0, 16'h0009, 16'd0);
    stop_sending();
  endtask

  task automatic test_steady_ride();
    ride_phase(210, 12'd2096, 0, 0);
  endtask

  task automatic test_sender_gaps();
    ride_phase(210, CIRC_W'($urandom_range(1500, 2300)), 79, 0);
  endtask

  task automatic test_receiver_stalls();
    ride_phase(210, 12'hFFF, 0, 79);
  endtask

  task automatic test_both_idle();
    ride_phase(240, 12'd1, 32, 32);
  endtask

  task automatic test_speed_disabled();
    ride_phase(120, 12'd0, 20, 20);
  endtask

  task automatic test_backpressure();
    sensor_item_t it;
    write_circ(12'd2096);
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (12) begin
      next_ride_item(it);
      send_item(it);
    end
    stop_sending();
    wait_drained();
    repeat (20) begin
      next_ride_item(it);
      send_item(it);
    end
    stop_sending();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_PACKET;
    crank_revs_i = '0;
    crank_time_i = '0;
    wheel_revs_i = '0;
    wheel_time_i = '0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_steady_ride();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_speed_disabled();
    test_backpressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls plus one long hold
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    ride_reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected transfer cadence %0d speed %0d", $time, cadence_rpm_o,
                 speed_mm_per_s_o);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (cadence_rpm_o !== want.cadence_rpm) begin
          $display("%0t: cadence_rpm expected %0d actual %0d", $time, want.cadence_rpm,
                   cadence_rpm_o);
          error_count++;
        end
        if (speed_mm_per_s_o !== want.speed_mm_per_s) begin
          $display("%0t: speed_mm_per_s expected %0d actual %0d", $time, want.speed_mm_per_s,
                   speed_mm_per_s_o);
          error_count++;
        end
        if (cadence_armed_o !== want.cadence_armed) begin
          $display("%0t: cadence_armed expected %0d actual %0d", $time, want.cadence_armed,
                   cadence_armed_o);
          error_count++;
        end
        if (speed_armed_o !== want.speed_armed) begin
          $display("%0t: speed_armed expected %0d actual %0d", $time, want.speed_armed,
                   speed_armed_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
